FILE: src/wsi_pkg.sv
// Shared widths, constants and interface types of the Wilson score interval block.
package wsi_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int OW     = FB + 1;
    localparam int ZW     = 15;
    localparam int ZF     = 12;
    localparam int IFRAC  = 40;
    localparam int P_W    = IFRAC + 1;
    localparam int Z2_W   = 2 * ZW;
    localparam int TSH    = IFRAC - 2 * ZF;
    localparam int T_W    = Z2_W + TSH;
    localparam int V_W    = T_W - 1;
    localparam int PROD_W = T_W + V_W;
    localparam int R_W    = (PROD_W + 1) / 2;
    localparam int SQ_W   = PROD_W + 1;
    localparam int DEN_W  = T_W + 1;
    localparam int SPL    = 24;
    localparam int PP_W   = 2 * SPL;
    localparam int QP_W   = 2 * P_W;
    localparam int RND    = IFRAC - FB;

    localparam logic [ZW-1:0]  Z_RESET = ZW'(8028);
    localparam logic [P_W-1:0] ONE_P   = {1'b1, {IFRAC{1'b0}}};
    localparam logic [OW-1:0]  ONE_O   = {1'b1, {FB{1'b0}}};
    localparam logic [OW-1:0]  HALF_O  = {2'b01, {(FB - 1){1'b0}}};

    typedef struct packed {
        logic [P_W-1:0] p;
        logic [T_W-1:0] t;
        logic           ovf;
        logic           nz;
    } wsi_front_t;

    typedef struct packed {
        logic [P_W-1:0] p;
        logic [T_W-1:0] t;
        logic [R_W-1:0] s;
        logic           ovf;
        logic           nz;
    } wsi_mid_t;

endpackage

FILE: src/wsi_front.sv
// Count saturation, z squared, and the bit-serial pipelined dividers for p and t.
module wsi_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [wsi_pkg::CW-1:0]          successes,
    input  logic [wsi_pkg::CW-1:0]          trials,
    input  logic [wsi_pkg::ZW-1:0]          z_score,
    output logic                            out_valid,
    output wsi_pkg::wsi_front_t             out_data
);

    typedef struct packed {
        logic [wsi_pkg::CW-1:0]   n;
        logic [wsi_pkg::Z2_W-1:0] z2;
        logic [wsi_pkg::CW-1:0]   tr;
        logic [wsi_pkg::T_W-1:0]  tq;
        logic [wsi_pkg::CW-1:0]   pr;
        logic [wsi_pkg::P_W-1:0]  pq;
        logic                     ovf;
        logic                     nz;
    } fstage_t;

    fstage_t fs_reg   [0:wsi_pkg::T_W];
    fstage_t fs_next  [0:wsi_pkg::T_W];
    logic    fv_reg   [0:wsi_pkg::T_W];

    always_comb
    begin
        fs_next[0].n   = trials;
        fs_next[0].z2  = wsi_pkg::Z2_W'(z_score) * wsi_pkg::Z2_W'(z_score);
        fs_next[0].tr  = '0;
        fs_next[0].tq  = '0;
        fs_next[0].pr  = (successes >= trials) ? '0 : successes;
        fs_next[0].pq  = {{(wsi_pkg::P_W - 1){1'b0}}, successes >= trials};
        fs_next[0].ovf = successes > trials;
        fs_next[0].nz  = (trials == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fs_reg[0] <= fs_next[0];
        end
    end

    for (genvar j = 0; j < wsi_pkg::T_W; j++)
    begin : g_step
        localparam int DB = wsi_pkg::T_W - 1 - j;
        logic                   dbit;
        logic [wsi_pkg::CW:0]   t_sh;
        logic                   t_ge;
        logic [wsi_pkg::CW:0]   p_sh;
        logic                   p_ge;

        if (DB >= wsi_pkg::TSH)
        begin : g_hi
            assign dbit = fs_reg[j].z2[DB - wsi_pkg::TSH];
        end
        else
        begin : g_lo
            assign dbit = 1'b0;
        end

        always_comb
        begin
            fs_next[j + 1] = fs_reg[j];
            t_sh = {fs_reg[j].tr, dbit};
            t_ge = t_sh >= {1'b0, fs_reg[j].n};
            fs_next[j + 1].tr = wsi_pkg::CW'(t_ge ? t_sh - {1'b0, fs_reg[j].n} : t_sh);
            fs_next[j + 1].tq = {fs_reg[j].tq[wsi_pkg::T_W-2:0], t_ge};
            p_sh = {fs_reg[j].pr, 1'b0};
            p_ge = p_sh >= {1'b0, fs_reg[j].n};
            if (j < wsi_pkg::IFRAC)
            begin
                fs_next[j + 1].pr = wsi_pkg::CW'(p_ge ? p_sh - {1'b0, fs_reg[j].n} : p_sh);
                fs_next[j + 1].pq = {fs_reg[j].pq[wsi_pkg::P_W-2:0], p_ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fv_reg[j + 1] <= 1'b0;
            end
            else if (adv)
            begin
                fv_reg[j + 1] <= fv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fs_reg[j + 1] <= fs_next[j + 1];
            end
        end
    end

    assign out_valid    = fv_reg[wsi_pkg::T_W];
    assign out_data.p   = fs_reg[wsi_pkg::T_W].pq;
    assign out_data.t   = fs_reg[wsi_pkg::T_W].tq;
    assign out_data.ovf = fs_reg[wsi_pkg::T_W].ovf;
    assign out_data.nz  = fs_reg[wsi_pkg::T_W].nz;

endmodule

FILE: src/wsi_mid.sv
// Split multipliers for p(1-p) and t*v, then the pipelined bit-serial square root.
module wsi_mid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  wsi_pkg::wsi_front_t  in_data,
    output logic                 out_valid,
    output wsi_pkg::wsi_mid_t    out_data
);

    typedef struct packed {
        logic [wsi_pkg::PP_W-1:0] pp0;
        logic [wsi_pkg::PP_W-1:0] pp1;
        logic [wsi_pkg::PP_W-1:0] pp2;
        logic [wsi_pkg::PP_W-1:0] pp3;
        logic [wsi_pkg::P_W-1:0]  p;
        logic [wsi_pkg::T_W-1:0]  t;
        logic                     ovf;
        logic                     nz;
    } pp_t;

    typedef struct packed {
        logic [wsi_pkg::V_W-1:0]  v;
        logic [wsi_pkg::P_W-1:0]  p;
        logic [wsi_pkg::T_W-1:0]  t;
        logic                     ovf;
        logic                     nz;
    } vq_t;

    typedef struct packed {
        logic [wsi_pkg::SQ_W-1:0] rem;
        logic [wsi_pkg::R_W-1:0]  root;
        logic [wsi_pkg::P_W-1:0]  p;
        logic [wsi_pkg::T_W-1:0]  t;
        logic                     ovf;
        logic                     nz;
    } sq_t;

    pp_t  a_reg, a_next, d_reg, d_next;
    vq_t  b_reg, b_next, c_reg, c_next;
    logic av_reg, bv_reg, cv_reg, dv_reg;
    sq_t  sq_reg  [0:wsi_pkg::R_W];
    sq_t  sq_next [0:wsi_pkg::R_W];
    logic sv_reg  [0:wsi_pkg::R_W];

    logic [wsi_pkg::P_W-1:0]  m;
    logic [wsi_pkg::QP_W-1:0] qprod;
    logic [wsi_pkg::PROD_W-1:0] xprod;

    always_comb
    begin
        m = wsi_pkg::ONE_P - in_data.p;
        a_next.pp0 = in_data.p[wsi_pkg::SPL-1:0] * m[wsi_pkg::SPL-1:0];
        a_next.pp1 = in_data.p[wsi_pkg::SPL-1:0] * m[wsi_pkg::P_W-1:wsi_pkg::SPL];
        a_next.pp2 = in_data.p[wsi_pkg::P_W-1:wsi_pkg::SPL] * m[wsi_pkg::SPL-1:0];
        a_next.pp3 = in_data.p[wsi_pkg::P_W-1:wsi_pkg::SPL] * m[wsi_pkg::P_W-1:wsi_pkg::SPL];
        a_next.p   = in_data.p;
        a_next.t   = in_data.t;
        a_next.ovf = in_data.ovf;
        a_next.nz  = in_data.nz;
    end

    always_comb
    begin
        qprod = wsi_pkg::QP_W'(a_reg.pp0)
              + (wsi_pkg::QP_W'(a_reg.pp1) << wsi_pkg::SPL)
              + (wsi_pkg::QP_W'(a_reg.pp2) << wsi_pkg::SPL)
              + (wsi_pkg::QP_W'(a_reg.pp3) << (2 * wsi_pkg::SPL));
        b_next.v   = wsi_pkg::V_W'(qprod >> wsi_pkg::IFRAC);
        b_next.p   = a_reg.p;
        b_next.t   = a_reg.t;
        b_next.ovf = a_reg.ovf;
        b_next.nz  = a_reg.nz;
    end

    always_comb
    begin
        c_next   = b_reg;
        c_next.v = b_reg.v + wsi_pkg::V_W'(b_reg.t >> 2);
    end

    always_comb
    begin
        d_next.pp0 = c_reg.t[wsi_pkg::SPL-1:0] * c_reg.v[wsi_pkg::SPL-1:0];
        d_next.pp1 = c_reg.t[wsi_pkg::SPL-1:0] * c_reg.v[wsi_pkg::V_W-1:wsi_pkg::SPL];
        d_next.pp2 = c_reg.t[wsi_pkg::T_W-1:wsi_pkg::SPL] * c_reg.v[wsi_pkg::SPL-1:0];
        d_next.pp3 = c_reg.t[wsi_pkg::T_W-1:wsi_pkg::SPL] * c_reg.v[wsi_pkg::V_W-1:wsi_pkg::SPL];
        d_next.p   = c_reg.p;
        d_next.t   = c_reg.t;
        d_next.ovf = c_reg.ovf;
        d_next.nz  = c_reg.nz;
    end

    always_comb
    begin
        xprod = wsi_pkg::PROD_W'(d_reg.pp0)
              + (wsi_pkg::PROD_W'(d_reg.pp1) << wsi_pkg::SPL)
              + (wsi_pkg::PROD_W'(d_reg.pp2) << wsi_pkg::SPL)
              + (wsi_pkg::PROD_W'(d_reg.pp3) << (2 * wsi_pkg::SPL));
        sq_next[0].rem  = wsi_pkg::SQ_W'(xprod);
        sq_next[0].root = '0;
        sq_next[0].p    = d_reg.p;
        sq_next[0].t    = d_reg.t;
        sq_next[0].ovf  = d_reg.ovf;
        sq_next[0].nz   = d_reg.nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            cv_reg    <= 1'b0;
            dv_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            av_reg    <= in_valid;
            bv_reg    <= av_reg;
            cv_reg    <= bv_reg;
            dv_reg    <= cv_reg;
            sv_reg[0] <= dv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            sq_reg[0] <= sq_next[0];
        end
    end

    for (genvar i = 0; i < wsi_pkg::R_W; i++)
    begin : g_sqrt
        localparam int B = wsi_pkg::R_W - 1 - i;
        logic [wsi_pkg::SQ_W-1:0] trial;
        logic                     ge;

        always_comb
        begin
            trial = (wsi_pkg::SQ_W'(sq_reg[i].root) << (B + 1))
                  | (wsi_pkg::SQ_W'(1) << (2 * B));
            ge = sq_reg[i].rem >= trial;
            sq_next[i + 1] = sq_reg[i];
            if (ge)
            begin
                sq_next[i + 1].rem     = sq_reg[i].rem - trial;
                sq_next[i + 1].root[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[i + 1] <= 1'b0;
            end
            else if (adv)
            begin
                sv_reg[i + 1] <= sv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[i + 1] <= sq_next[i + 1];
            end
        end
    end

    assign out_valid    = sv_reg[wsi_pkg::R_W];
    assign out_data.p   = sq_reg[wsi_pkg::R_W].p;
    assign out_data.t   = sq_reg[wsi_pkg::R_W].t;
    assign out_data.s   = sq_reg[wsi_pkg::R_W].root;
    assign out_data.ovf = sq_reg[wsi_pkg::R_W].ovf;
    assign out_data.nz  = sq_reg[wsi_pkg::R_W].nz;

endmodule

FILE: src/wsi_back.sv
// Pipelined dividers for center and half width, clamping, rounding and the output register.
module wsi_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  wsi_pkg::wsi_mid_t     in_data,
    output logic                  out_valid,
    output logic [wsi_pkg::OW-1:0] lower_bound,
    output logic [wsi_pkg::OW-1:0] upper_bound,
    output logic [wsi_pkg::OW-1:0] midpoint,
    output logic                  count_overflow
);

    typedef struct packed {
        logic [wsi_pkg::DEN_W-1:0] den;
        logic [wsi_pkg::DEN_W-1:0] cn;
        logic [wsi_pkg::DEN_W-1:0] hs;
        logic                      ovf;
        logic                      nz;
    } prep_t;

    typedef struct packed {
        logic [wsi_pkg::DEN_W-1:0] den;
        logic [wsi_pkg::DEN_W-1:0] cr;
        logic [wsi_pkg::P_W-1:0]   cq;
        logic [wsi_pkg::DEN_W-1:0] hr;
        logic [wsi_pkg::P_W-1:0]   hq;
        logic                      ovf;
        logic                      nz;
    } dv_t;

    typedef struct packed {
        logic [wsi_pkg::P_W-1:0] lo;
        logic [wsi_pkg::P_W-1:0] up;
        logic [wsi_pkg::P_W-1:0] cc;
        logic                    ovf;
        logic                    nz;
    } bnd_t;

    function automatic logic [wsi_pkg::OW-1:0] round_out(input logic [wsi_pkg::P_W-1:0] x);
        logic [wsi_pkg::P_W-1:0] sum;
        logic [wsi_pkg::OW-1:0]  y;
        sum = x + (wsi_pkg::P_W'(1) << (wsi_pkg::RND - 1));
        y   = wsi_pkg::OW'(sum >> wsi_pkg::RND);
        return (y > wsi_pkg::ONE_O) ? wsi_pkg::ONE_O : y;
    endfunction

    prep_t pr_reg, pr_next;
    logic  prv_reg;
    dv_t   dv_reg  [0:wsi_pkg::IFRAC];
    dv_t   dv_next [0:wsi_pkg::IFRAC];
    logic  dvv_reg [0:wsi_pkg::IFRAC];
    bnd_t  bd_reg, bd_next;
    logic  bdv_reg;
    logic  ov_reg;
    logic [wsi_pkg::OW-1:0] lower_reg, lower_next;
    logic [wsi_pkg::OW-1:0] upper_reg, upper_next;
    logic [wsi_pkg::OW-1:0] mid_reg, mid_next;
    logic  ovf_reg;

    logic [wsi_pkg::P_W-1:0] c_last, h_last;
    logic [wsi_pkg::P_W:0]   up_sum;
    logic                    c_ge, h_ge;

    always_comb
    begin
        pr_next.den = wsi_pkg::DEN_W'(wsi_pkg::ONE_P) + wsi_pkg::DEN_W'(in_data.t);
        pr_next.cn  = wsi_pkg::DEN_W'(in_data.p) + wsi_pkg::DEN_W'(in_data.t >> 1);
        pr_next.hs  = wsi_pkg::DEN_W'(in_data.s);
        pr_next.ovf = in_data.ovf;
        pr_next.nz  = in_data.nz;
    end

    always_comb
    begin
        c_ge = pr_reg.cn >= pr_reg.den;
        h_ge = pr_reg.hs >= pr_reg.den;
        dv_next[0].den = pr_reg.den;
        dv_next[0].cr  = c_ge ? pr_reg.cn - pr_reg.den : pr_reg.cn;
        dv_next[0].cq  = {{(wsi_pkg::P_W - 1){1'b0}}, c_ge};
        dv_next[0].hr  = h_ge ? pr_reg.hs - pr_reg.den : pr_reg.hs;
        dv_next[0].hq  = {{(wsi_pkg::P_W - 1){1'b0}}, h_ge};
        dv_next[0].ovf = pr_reg.ovf;
        dv_next[0].nz  = pr_reg.nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prv_reg    <= 1'b0;
            dvv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            prv_reg    <= in_valid;
            dvv_reg[0] <= prv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg     <= pr_next;
            dv_reg[0]  <= dv_next[0];
        end
    end

    for (genvar j = 0; j < wsi_pkg::IFRAC; j++)
    begin : g_div
        logic [wsi_pkg::DEN_W:0] c_sh, h_sh;
        logic                    cg, hg;

        always_comb
        begin
            dv_next[j + 1] = dv_reg[j];
            c_sh = {dv_reg[j].cr, 1'b0};
            h_sh = {dv_reg[j].hr, 1'b0};
            cg = c_sh >= {1'b0, dv_reg[j].den};
            hg = h_sh >= {1'b0, dv_reg[j].den};
            dv_next[j + 1].cr = wsi_pkg::DEN_W'(cg ? c_sh - {1'b0, dv_reg[j].den} : c_sh);
            dv_next[j + 1].hr = wsi_pkg::DEN_W'(hg ? h_sh - {1'b0, dv_reg[j].den} : h_sh);
            dv_next[j + 1].cq = {dv_reg[j].cq[wsi_pkg::P_W-2:0], cg};
            dv_next[j + 1].hq = {dv_reg[j].hq[wsi_pkg::P_W-2:0], hg};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvv_reg[j + 1] <= 1'b0;
            end
            else if (adv)
            begin
                dvv_reg[j + 1] <= dvv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j + 1] <= dv_next[j + 1];
            end
        end
    end

    always_comb
    begin
        c_last = dv_reg[wsi_pkg::IFRAC].cq;
        h_last = dv_reg[wsi_pkg::IFRAC].hq;
        up_sum = {1'b0, c_last} + {1'b0, h_last};
        bd_next.lo  = (c_last > h_last) ? c_last - h_last : '0;
        bd_next.up  = (up_sum > {1'b0, wsi_pkg::ONE_P}) ? wsi_pkg::ONE_P
                                                         : wsi_pkg::P_W'(up_sum);
        bd_next.cc  = (c_last > wsi_pkg::ONE_P) ? wsi_pkg::ONE_P : c_last;
        bd_next.ovf = dv_reg[wsi_pkg::IFRAC].ovf;
        bd_next.nz  = dv_reg[wsi_pkg::IFRAC].nz;
    end

    always_comb
    begin
        if (bd_reg.nz)
        begin
            lower_next = '0;
            upper_next = wsi_pkg::ONE_O;
            mid_next   = wsi_pkg::HALF_O;
        end
        else
        begin
            lower_next = round_out(bd_reg.lo);
            upper_next = round_out(bd_reg.up);
            mid_next   = round_out(bd_reg.cc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bdv_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            bdv_reg <= dvv_reg[wsi_pkg::IFRAC];
            ov_reg  <= bdv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bd_reg    <= bd_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            mid_reg   <= mid_next;
            ovf_reg   <= bd_reg.ovf;
        end
    end

    assign out_valid      = ov_reg;
    assign lower_bound    = lower_reg;
    assign upper_bound    = upper_reg;
    assign midpoint       = mid_reg;
    assign count_overflow = ovf_reg;

endmodule

FILE: src/wilson_score_interval.sv
// Top level of the Wilson score interval block: config register, pipeline control and stages.
// Each word of (successes, trials) yields one word of interval bounds, center and an overflow
// flag. A new word is accepted every cycle while not stalled; the stages are the bit-serial
// pipelined dividers for p and t (47 stages), the multipliers and the square root (51 stages)
// and the center and half-width dividers with rounding (44 stages). The pipeline advances
// whenever the output register is empty or being taken, so in_ready follows out_ready.
// The z score register resets to 8028 (about 1.96) and should be written only while idle.
module wilson_score_interval (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [wsi_pkg::ZW-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [wsi_pkg::CW-1:0] successes,
    input  logic [wsi_pkg::CW-1:0] trials,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [wsi_pkg::OW-1:0] lower_bound,
    output logic [wsi_pkg::OW-1:0] upper_bound,
    output logic [wsi_pkg::OW-1:0] midpoint,
    output logic                   count_overflow
);

    logic [wsi_pkg::ZW-1:0] z_reg;
    logic                   adv;
    logic                   f_valid, m_valid;
    wsi_pkg::wsi_front_t    f_data;
    wsi_pkg::wsi_mid_t      m_data;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg <= wsi_pkg::Z_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            z_reg <= cfg_data;
        end
    end

    wsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .successes (successes),
        .trials    (trials),
        .z_score   (z_reg),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    wsi_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    wsi_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (m_valid),
        .in_data        (m_data),
        .out_valid      (out_valid),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .midpoint       (midpoint),
        .count_overflow (count_overflow)
    );

endmodule

FILE: src/wsi_checker.sv
// Port-level checks of the Wilson score interval block and their binding to the top level.
module wsi_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_ready,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [wsi_pkg::OW-1:0] lower_bound,
    input  logic [wsi_pkg::OW-1:0] upper_bound,
    input  logic [wsi_pkg::OW-1:0] midpoint
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(midpoint))
        else $error("Output word dropped or changed while stalled.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lower_bound <= midpoint && midpoint <= upper_bound)
        else $error("Interval bounds are out of order.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> upper_bound <= wsi_pkg::ONE_O)
        else $error("Upper bound exceeds one.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("Input stalled without a stalled output word.");

endmodule

bind wilson_score_interval wsi_checker u_wsi_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the Wilson score interval block with a built-in fixed-point predictor.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [wsi_pkg::CW-1:0] k;
        logic [wsi_pkg::CW-1:0] n;
    } count_pair_t;

    typedef struct {
        logic [wsi_pkg::OW-1:0] lo;
        logic [wsi_pkg::OW-1:0] up;
        logic [wsi_pkg::OW-1:0] mid;
        logic                   ovf;
    } interval_t;

    localparam int PIPE_DEPTH = 142;
    localparam int HOLD_LEN   = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [wsi_pkg::ZW-1:0] cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [wsi_pkg::CW-1:0] successes = '0;
    logic [wsi_pkg::CW-1:0] trials = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [wsi_pkg::OW-1:0] lower_bound;
    logic [wsi_pkg::OW-1:0] upper_bound;
    logic [wsi_pkg::OW-1:0] midpoint;
    logic                   count_overflow;

    count_pair_t            pair_q[$];
    interval_t              interval_q[$];
    logic [wsi_pkg::ZW-1:0] z_now = wsi_pkg::Z_RESET;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    logic                   hold_go = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_count = 0;
    int                     fail_count = 0;
    logic                   in_ready_seen = 1'b0;

    wilson_score_interval u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .successes(successes), .trials(trials),
        .out_valid(out_valid), .out_ready(out_ready),
        .lower_bound(lower_bound), .upper_bound(upper_bound),
        .midpoint(midpoint), .count_overflow(count_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [wsi_pkg::OW-1:0] round_out(logic [63:0] x);
        logic [63:0] y;
        y = (x + (64'd1 << (wsi_pkg::RND - 1))) >> wsi_pkg::RND;
        return (y > (64'd1 << wsi_pkg::FB)) ? wsi_pkg::ONE_O : y[wsi_pkg::OW-1:0];
    endfunction

    function automatic interval_t wilson_interval(count_pair_t c,
                                                  logic [wsi_pkg::ZW-1:0] z);
        interval_t     r;
        logic [63:0]   k, n, p, t, q, v, s, den, ctr, half, lo, up;
        logic [63:0]   one;
        logic [127:0]  prod, cand;
        one = 64'd1 << wsi_pkg::IFRAC;
        k = 64'(c.k);
        n = 64'(c.n);
        r.ovf = (k > n);
        if (k > n)
            k = n;
        if (n == 64'd0)
        begin
            r.lo = '0;
            r.up = wsi_pkg::ONE_O;
            r.mid = wsi_pkg::HALF_O;
            return r;
        end
        p = 64'(({64'd0, k} << wsi_pkg::IFRAC) / n);
        t = 64'(({64'd0, 64'(z) * 64'(z)} << wsi_pkg::TSH) / n);
        prod = 128'(p) * 128'(one - p);
        q = 64'(prod >> wsi_pkg::IFRAC);
        v = q + (t >> 2);
        prod = 128'(t) * 128'(v);
        s = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = 128'(s | (64'd1 << b));
            if (cand * cand <= prod)
                s = s | (64'd1 << b);
        end
        den = one + t;
        ctr = 64'((128'(p + (t >> 1)) << wsi_pkg::IFRAC) / den);
        half = 64'((128'(s) << wsi_pkg::IFRAC) / den);
        lo = (ctr > half) ? ctr - half : 64'd0;
        up = ctr + half;
        if (up > one)
            up = one;
        if (ctr > one)
            ctr = one;
        r.lo = round_out(lo);
        r.up = round_out(up);
        r.mid = round_out(ctr);
        return r;
    endfunction

    task automatic add_pair(logic [wsi_pkg::CW-1:0] k, logic [wsi_pkg::CW-1:0] n);
        count_pair_t c;
        c.k = k;
        c.n = n;
        pair_q.push_back(c);
    endtask

    function automatic logic [wsi_pkg::CW-1:0] rand_count();
        case ($urandom_range(0, 4))
            0: return wsi_pkg::CW'($urandom_range(0, 20));
            1: return wsi_pkg::CW'($urandom_range(0, 1000));
            2: return wsi_pkg::CW'($urandom & 32'h000F_FFFF);
            default: return wsi_pkg::CW'($urandom);
        endcase
    endfunction

    task automatic add_random(int count);
        logic [wsi_pkg::CW-1:0] n;
        for (int i = 0; i < count; i++)
        begin
            n = rand_count();
            case ($urandom_range(0, 9))
                0: add_pair(rand_count(), n);
                1: add_pair(n + wsi_pkg::CW'($urandom_range(1, 50)), n);
                default: add_pair(wsi_pkg::CW'(33'($urandom) % (33'(n) + 33'd1)), n);
            endcase
        end
    endtask

    task automatic write_z(logic [wsi_pkg::ZW-1:0] z);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= z;
        do
            @(posedge clk);
        while (!cfg_ready);
        z_now = z;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pair_q.size() != 0 || interval_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((!in_valid || in_ready_seen) && pair_q.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                successes <= pair_q[0].k;
                trials <= pair_q[0].n;
                void'(pair_q.pop_front());
            end
            else if (in_valid && in_ready_seen)
            begin
                in_valid <= 1'b0;
            end
            out_ready <= (hold_go && !hold_done) ? 1'b0
                                                 : ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_LEN - 1)
                hold_done <= 1'b1;
        end
    end

    // The expected word is computed at acceptance, with the z score then in force.
    always @(posedge clk)
    begin
        in_ready_seen <= 1'b0;
        if (in_valid && in_ready)
        begin
            in_ready_seen <= 1'b1;
            interval_q.push_back(wilson_interval('{successes, trials}, z_now));
        end
    end

    always @(posedge clk)
    begin
        interval_t e;
        if (out_valid && out_ready)
        begin
            if (interval_q.size() == 0)
            begin
                $display("%0t: unexpected word lo=%0d up=%0d mid=%0d ovf=%0d", $realtime,
                         lower_bound, upper_bound, midpoint, count_overflow);
                fail_count++;
            end
            else
            begin
                e = interval_q.pop_front();
                if (e.lo !== lower_bound || e.up !== upper_bound || e.mid !== midpoint
                    || e.ovf !== count_overflow)
                begin
                    $display("%0t: expected lo=%0d up=%0d mid=%0d ovf=%0d, got %0d %0d %0d %0d",
                             $realtime, e.lo, e.up, e.mid, e.ovf,
                             lower_bound, upper_bound, midpoint, count_overflow);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        add_pair('0, '0);
        add_pair(32'd5, '0);
        add_pair('0, 32'd1);
        add_pair(32'd1, 32'd1);
        add_pair(32'd2, 32'd1);
        add_pair('1, '1);
        add_pair('0, '1);
        add_pair('1, 32'd7);
        add_pair(32'h8000_0000, '1);
        add_pair(32'd1, '1);
        add_pair(32'd50, 32'd100);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);
        add_pair(32'd3, 32'd10);
        add_random(280);
        send_idle_pct = 27;
        recv_idle_pct = 47;
        drain();
        write_z('0);
        add_pair(32'd3, 32'd10);
        add_pair(32'd1, 32'd1);
        add_random(300);
        drain();
        write_z('1);
        send_idle_pct = 47;
        recv_idle_pct = 27;
        add_pair('0, 32'd1);
        add_pair(32'd1, 32'd2);
        add_pair('1, '1);
        add_random(300);
        drain();
        write_z(wsi_pkg::ZW'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(450);
        hold_go = 1'b1;
        drain();
        write_z(wsi_pkg::Z_RESET);
        add_random(450);
        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: files.f
src/wsi_pkg.sv
src/wsi_front.sv
src/wsi_mid.sv
src/wsi_back.sv
src/wilson_score_interval.sv
src/wsi_checker.sv
verif/tb_top.sv
